// ----- rtl/hsv_pkg.sv -----
// Shared constants and types of the RGB to HSV converter.
package hsv_pkg;

  localparam int CHAN_W     = 8;
  localparam int HUE_W      = 13;

  // Restoring divider: one quotient bit per pipeline step.
  localparam int DIV_STEPS  = 10;
  localparam int DIV_Q_W    = DIV_STEPS;
  localparam int DIV_NUM_W  = 18;
  localparam int DIV_DEN_W  = CHAN_W;

  localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(960);
  localparam logic [HUE_W-1:0] HUE_FULL   = HUE_W'(5760);

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // Per-pixel data that rides alongside the dividers.
  typedef struct packed {
    logic [1:0]        sector;
    logic              neg;
    logic              grey;
    logic [CHAN_W-1:0] value;
  } hsv_side_t;

endpackage

// ----- rtl/rgb_to_hsv_converter_unit.sv -----
// Top level of the RGB to HSV converter: a twelve-stage pixel pipeline.
//
// Converts one 8-bit RGB pixel into hue (1/16 degree, 0..5759), saturation
// (0..255) and value (the largest channel). The unit takes one pixel per
// clock while the output is not stalled. Each pixel's input transaction
// loads the preparation stage (max, min, sector, scaled numerators), then
// ten stages of two restoring dividers resolve one quotient bit each (the
// hue quotient reaches 960, so ten bits set the depth), and one more stage
// adds the sector base, wraps negative hues and registers the result. Every
// stage carries its own valid bit and advances whenever it is empty or the
// stage after it moves, so bubbles collapse and a stalled output holds only
// the stages behind it that are full. Grey pixels give hue 0 and
// saturation 0. Ties for the largest channel go to red, then green. Reset
// clears only the valid bits.
module rgb_to_hsv_converter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hsv_pkg::CHAN_W-1:0] in_red,
  input  logic [hsv_pkg::CHAN_W-1:0] in_green,
  input  logic [hsv_pkg::CHAN_W-1:0] in_blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hsv_pkg::HUE_W-1:0]  out_hue,
  output logic [hsv_pkg::CHAN_W-1:0] out_saturation,
  output logic [hsv_pkg::CHAN_W-1:0] out_value
);
  import hsv_pkg::*;

  localparam int NSTG = DIV_STEPS + 2;   // prep, divider steps, output
  localparam int OUTS = NSTG - 1;

  // Valid bits and advance enables, one per stage.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  // Preparation stage registers.
  logic [DIV_NUM_W-1:0] num_sat_r, num_hue_r;
  logic [DIV_DEN_W-1:0] den_sat_r, den_hue_r;
  hsv_side_t            side_r [DIV_STEPS+1];

  logic [DIV_Q_W-1:0]   q_sat, q_hue;

  // Output register.
  logic [HUE_W-1:0]  out_hue_r;
  logic [CHAN_W-1:0] out_sat_r, out_val_r;

  // Stage enables: advance a stage when it is empty or its successor moves.
  always_comb begin
    adv[OUTS] = !v_r[OUTS] || out_ready;
    for (int i = OUTS - 1; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Preparation: pick the largest channel and its sector, form delta and
  // the signed channel difference, and scale the dividends with shifts
  // (x*255 = x*256 - x, x*960 = x*1024 - x*64).
  // ---------------------------------------------------------------------
  logic [CHAN_W-1:0]    hi, lo, delta, mag;
  logic [CHAN_W:0]      diff;
  logic [1:0]           sector;
  logic [DIV_NUM_W-1:0] num_sat_nxt, num_hue_nxt;
  hsv_side_t            side_nxt;

  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      sector = SEC_RED;
      hi     = in_red;
      diff   = {1'b0, in_green} - {1'b0, in_blue};
    end else if (in_green >= in_blue) begin
      sector = SEC_GREEN;
      hi     = in_green;
      diff   = {1'b0, in_blue} - {1'b0, in_red};
    end else begin
      sector = SEC_BLUE;
      hi     = in_blue;
      diff   = {1'b0, in_red} - {1'b0, in_green};
    end

    lo = in_red;
    if (in_green < lo) begin
      lo = in_green;
    end
    if (in_blue < lo) begin
      lo = in_blue;
    end
    delta = hi - lo;

    // magnitude of the 9-bit two's complement difference
    mag = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];

    num_sat_nxt = (DIV_NUM_W'(delta) << 8) - DIV_NUM_W'(delta);
    num_hue_nxt = (DIV_NUM_W'(mag) << 10) - (DIV_NUM_W'(mag) << 6);

    side_nxt.sector = sector;
    side_nxt.neg    = diff[CHAN_W];
    side_nxt.grey   = (delta == '0);
    side_nxt.value  = hi;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      num_sat_r <= num_sat_nxt;
      num_hue_r <= num_hue_nxt;
      den_sat_r <= hi;
      den_hue_r <= delta;
      side_r[0] <= side_nxt;
    end
    for (int i = 1; i <= DIV_STEPS; i++) begin
      if (adv[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Dividers: saturation = delta*255 / max, hue offset = |diff|*960 / delta.
  // Both quotients fit ten bits; a grey pixel divides by zero and its
  // quotients are discarded at the output stage.
  // ---------------------------------------------------------------------
  hsv_div u_div_sat (
    .clk      (clk),
    .en       (adv[DIV_STEPS:1]),
    .dividend (num_sat_r),
    .divisor  (den_sat_r),
    .quotient (q_sat)
  );

  hsv_div u_div_hue (
    .clk      (clk),
    .en       (adv[DIV_STEPS:1]),
    .dividend (num_hue_r),
    .divisor  (den_hue_r),
    .quotient (q_hue)
  );

  // ---------------------------------------------------------------------
  // Output stage: add the sector base, apply the sign, wrap below zero.
  // ---------------------------------------------------------------------
  hsv_side_t        side_d;
  logic [HUE_W-1:0] base, q_ext, hue_nxt;
  logic [CHAN_W-1:0] sat_nxt;

  always_comb begin
    side_d = side_r[DIV_STEPS];
    q_ext  = HUE_W'(q_hue);
    case (side_d.sector)
      SEC_RED:   base = '0;
      SEC_GREEN: base = HUE_SECTOR << 1;
      SEC_BLUE:  base = HUE_SECTOR << 2;
      default:   base = '0;
    endcase

    if (!side_d.neg) begin
      hue_nxt = base + q_ext;
    end else if (base >= q_ext) begin
      hue_nxt = base - q_ext;
    end else begin
      hue_nxt = base + HUE_FULL - q_ext;
    end
    sat_nxt = q_sat[CHAN_W-1:0];

    if (side_d.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUTS]) begin
      out_hue_r <= hue_nxt;
      out_sat_r <= sat_nxt;
      out_val_r <= side_d.value;
    end
  end

  assign out_valid      = v_r[OUTS];
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_value      = out_val_r;

endmodule

// ----- rtl/hsv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module hsv_div (
  input  logic                            clk,
  input  logic [hsv_pkg::DIV_STEPS-1:0]   en,
  input  logic [hsv_pkg::DIV_NUM_W-1:0]   dividend,
  input  logic [hsv_pkg::DIV_DEN_W-1:0]   divisor,
  output logic [hsv_pkg::DIV_Q_W-1:0]     quotient
);
  import hsv_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r   [DIV_STEPS-1];
  logic [DIV_DEN_W-1:0] den_r   [DIV_STEPS-1];
  logic [DIV_Q_W-1:0]   quo_r   [DIV_STEPS];

  logic [DIV_NUM_W-1:0] rem_in  [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_in  [DIV_STEPS];
  logic [DIV_Q_W-1:0]   quo_in  [DIV_STEPS];
  logic [DIV_NUM_W-1:0] rem_nxt [DIV_STEPS];
  logic [DIV_Q_W-1:0]   quo_nxt [DIV_STEPS];

  always_comb begin
    logic [DIV_NUM_W-1:0] trial;
    rem_in[0] = dividend;
    den_in[0] = divisor;
    quo_in[0] = '0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_in[k] = rem_r[k-1];
      den_in[k] = den_r[k-1];
      quo_in[k] = quo_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      // try the divisor at the weight of this quotient bit
      trial = DIV_NUM_W'(den_in[k]) << (DIV_STEPS - 1 - k);
      if (rem_in[k] >= trial) begin
        rem_nxt[k] = rem_in[k] - trial;
        quo_nxt[k] = quo_in[k] | (DIV_Q_W'(1) << (DIV_STEPS - 1 - k));
      end else begin
        rem_nxt[k] = rem_in[k];
        quo_nxt[k] = quo_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS - 1; k++) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_in[k];
      end
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (en[k]) begin
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quotient = quo_r[DIV_STEPS-1];

endmodule
